// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the top-level RTL file
// Clocked, reset-qualified property wrappers that report through $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must never be seen
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error(msg);

`endif

// ===== design/md5sh_pkg.sv =====
// ----------------------------------------------------------------------------
// md5sh_pkg
// Shared types, constants and round tables of the streaming MD5 hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package md5sh_pkg;

    // Initial chaining values A, B, C, D
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    // Padding marker byte
    localparam logic [7:0] PAD_MARK = 8'h80;

    // Block kinds fed to the compression
    localparam logic [1:0] KIND_DATA     = 2'd0; // full block of message bytes
    localparam logic [1:0] KIND_PAD_LEN  = 2'd1; // tail, marker and length
    localparam logic [1:0] KIND_PAD_ONLY = 2'd2; // tail and marker, no room for length
    localparam logic [1:0] KIND_LEN_ONLY = 2'd3; // zeros and length

    // Message words that carry the bit length in a length block
    localparam logic [3:0] LEN_LO_WORD = 4'd14;
    localparam logic [3:0] LEN_HI_WORD = 4'd15;

    // Fill level from which the length no longer fits
    localparam logic [5:0] LEN_ROOM = 6'd56;

    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [5:0] LAST_BYTE  = 6'd63;
    localparam logic [1:0] LAST_WORD  = 2'd3;

    localparam logic [31:0] SINE_TABLE [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Controller to datapath commands
    typedef struct packed {
        logic       byte_wr;  // store the incoming byte and count it
        logic       load;     // copy chaining words into the round registers
        logic       round;    // run one compression round
        logic [5:0] rnd;      // current round number
        logic       finish;   // fold the round registers into the chain
        logic       reinit;   // restore initial chain and clear the length
        logic [1:0] kind;     // block kind under compression
        logic [1:0] out_idx;  // digest word to present
    } md5sh_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [5:0] fill;     // bytes held in the current block
    } md5sh_status_t;

    // Message word used by a round
    function automatic logic [3:0] md5sh_msg_idx(input logic [5:0] rnd);
        logic [3:0] low;
        logic [3:0] idx;
        low = rnd[3:0];
        case (rnd[5:4])
            2'd0:    idx = low;
            2'd1:    idx = 4'(low * 4'd5 + 4'd1);
            2'd2:    idx = 4'(low * 4'd3 + 4'd5);
            default: idx = 4'(low * 4'd7);
        endcase
        return idx;
    endfunction

    // Rotate amount of a round
    function automatic logic [4:0] md5sh_shift(input logic [5:0] rnd);
        logic [4:0] s;
        case ({rnd[5:4], rnd[1:0]})
            4'h0: s = 5'd7;
            4'h1: s = 5'd12;
            4'h2: s = 5'd17;
            4'h3: s = 5'd22;
            4'h4: s = 5'd5;
            4'h5: s = 5'd9;
            4'h6: s = 5'd14;
            4'h7: s = 5'd20;
            4'h8: s = 5'd4;
            4'h9: s = 5'd11;
            4'ha: s = 5'd16;
            4'hb: s = 5'd23;
            4'hc: s = 5'd6;
            4'hd: s = 5'd10;
            4'he: s = 5'd15;
            default: s = 5'd21;
        endcase
        return s;
    endfunction

    // Rotate a word left
    function automatic logic [31:0] md5sh_rotl(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] wide;
        wide = {v, v} << s;
        return wide[63:32];
    endfunction

endpackage

`default_nettype wire

// ===== design/md5_stream_hasher_unit.sv =====
// ----------------------------------------------------------------------------
// md5_stream_hasher_unit: streaming MD5 over a byte stream, tlast ends a message
// One byte per cycle while idle; the byte completing a block stalls input for
// load, 64 rounds of the shared round unit and chain fold. An end item runs
// one or two passes, then four digest words; aresetn (sync) restores the IV.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module md5_stream_hasher_unit import md5sh_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] byte_present
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [1:0]  m_tuser,   // [1:0] word_sel
    output logic        m_tlast    // last_word
);

    md5sh_cmd_t    cmd;
    md5sh_status_t status;

    md5sh_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_byte   (s_tuser[0]),
        .in_end    (s_tlast),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    md5sh_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .data_byte   (s_tdata),
        .status      (status),
        .digest_word (m_tdata)
    );

    // Present the digest word index and mark the last word
    assign m_tuser = cmd.out_idx;
    assign m_tlast = (cmd.out_idx == LAST_WORD);

    // Input and output sides are never open together
    `ASSERT_NEVER(a_sides_exclusive, aclk, aresetn, s_tready && m_tvalid,
        "input ready while digest is being delivered")

    // An end transaction always starts a compression pass
    `ASSERT_NEXT(a_end_starts_pass, aclk, aresetn, s_tvalid && s_tready && s_tlast,
        !s_tready && !m_tvalid, "end transaction did not start padding")

    // Digest words come out in order
    `ASSERT_NEXT(a_words_in_order, aclk, aresetn, m_tvalid && m_tready && !m_tlast,
        m_tvalid && (m_tuser == 2'($past(m_tuser) + 2'd1)), "digest word skipped")

    // The last digest word returns the block to taking bytes
    `ASSERT_NEXT(a_last_word_idle, aclk, aresetn, m_tvalid && m_tready && m_tlast,
        s_tready && !m_tvalid, "block not idle after last digest word")

endmodule

`default_nettype wire

// ===== design/md5sh_ctrl.sv =====
// ----------------------------------------------------------------------------
// md5sh_ctrl
// Sequencer: takes bytes, starts block compressions, walks the padding blocks
// and hands out the four digest words.
// ----------------------------------------------------------------------------
`default_nettype none

module md5sh_ctrl import md5sh_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    input  logic          in_byte,
    input  logic          in_end,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  md5sh_status_t status,
    output md5sh_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_ROUND  = 3'd2;
    localparam logic [2:0] ST_FINISH = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [1:0] kind_reg, kind_next;
    logic       end_pend_reg, end_pend_next;
    logic [5:0] rnd_reg, rnd_next;
    logic [1:0] idx_reg, idx_next;

    logic       in_fire;
    logic       wrap;
    logic [5:0] fill_after;

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = (state_reg == ST_EMIT);
    assign in_fire    = in_valid && in_ready;
    assign wrap       = in_byte && (status.fill == LAST_BYTE);
    assign fill_after = status.fill + {5'd0, in_byte};

    // Next state and commands
    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        end_pend_next = end_pend_reg;
        rnd_next      = rnd_reg;
        idx_next      = idx_reg;

        cmd         = '0;
        cmd.rnd     = rnd_reg;
        cmd.kind    = kind_reg;
        cmd.out_idx = idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    cmd.byte_wr = in_byte;
                    if (wrap) begin
                        kind_next     = KIND_DATA;
                        end_pend_next = in_end;
                        state_next    = ST_LOAD;
                    end else if (in_end) begin
                        kind_next  = (fill_after < LEN_ROOM) ? KIND_PAD_LEN : KIND_PAD_ONLY;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round = 1'b1;
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == LAST_ROUND) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                case (kind_reg)
                    KIND_DATA: begin
                        if (end_pend_reg) begin
                            end_pend_next = 1'b0;
                            kind_next     = KIND_PAD_LEN;
                            state_next    = ST_LOAD;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                    KIND_PAD_ONLY: begin
                        kind_next  = KIND_LEN_ONLY;
                        state_next = ST_LOAD;
                    end
                    default: begin
                        idx_next   = 2'd0;
                        state_next = ST_EMIT;
                    end
                endcase
            end
            ST_EMIT: begin
                if (out_ready) begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == LAST_WORD) begin
                        cmd.reinit = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            kind_reg     <= KIND_DATA;
            end_pend_reg <= 1'b0;
            rnd_reg      <= 6'd0;
            idx_reg      <= 2'd0;
        end else begin
            state_reg    <= state_next;
            kind_reg     <= kind_next;
            end_pend_reg <= end_pend_next;
            rnd_reg      <= rnd_next;
            idx_reg      <= idx_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/md5sh_datapath.sv =====
// ----------------------------------------------------------------------------
// md5sh_datapath
// Block buffer, length counter, chaining words and the one-round-per-cycle
// compression unit.
// ----------------------------------------------------------------------------
`default_nettype none

module md5sh_datapath import md5sh_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  md5sh_cmd_t    cmd,
    input  logic [7:0]    data_byte,
    output md5sh_status_t status,
    output logic [31:0]   digest_word
);

    logic [31:0] buf_mem [16];
    logic [31:0] rd_word_reg;
    logic [3:0]  rd_idx_reg;
    logic [3:0]  rd_addr;

    logic [60:0] byte_cnt_reg;
    logic [63:0] bit_len;
    logic [5:0]  fill;

    logic [31:0] chain_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;

    logic [31:0] msg_word;
    logic [31:0] f_val;
    logic [31:0] sum;
    logic [31:0] b_new;
    logic        pad_blk;
    logic        len_blk;

    assign fill        = byte_cnt_reg[5:0];
    assign bit_len     = {byte_cnt_reg, 3'b000};
    assign status.fill = fill;
    assign digest_word = chain_reg[cmd.out_idx];

    // Store incoming bytes in their lane
    always_ff @(posedge aclk) begin
        if (cmd.byte_wr) begin
            buf_mem[fill[5:2]][{fill[1:0], 3'b000} +: 8] <= data_byte;
        end
    end

    // Prefetch the message word of the next round
    assign rd_addr = cmd.round ? md5sh_msg_idx(cmd.rnd + 6'd1) : md5sh_msg_idx(cmd.rnd);

    always_ff @(posedge aclk) begin
        rd_word_reg <= buf_mem[rd_addr];
        rd_idx_reg  <= rd_addr;
    end

    // Overlay padding marker, zeros and length on the stored word
    assign pad_blk = (cmd.kind == KIND_PAD_LEN) || (cmd.kind == KIND_PAD_ONLY);
    assign len_blk = (cmd.kind == KIND_PAD_LEN) || (cmd.kind == KIND_LEN_ONLY);

    always_comb begin
        logic [5:0] byte_idx;
        msg_word = '0;
        for (int l = 0; l < 4; l++) begin
            byte_idx = {rd_idx_reg, 2'(l)};
            if (cmd.kind == KIND_DATA) begin
                msg_word[8*l +: 8] = rd_word_reg[8*l +: 8];
            end else if (pad_blk && (byte_idx < fill)) begin
                msg_word[8*l +: 8] = rd_word_reg[8*l +: 8];
            end else if (pad_blk && (byte_idx == fill)) begin
                msg_word[8*l +: 8] = PAD_MARK;
            end else begin
                msg_word[8*l +: 8] = 8'h00;
            end
        end
        if (len_blk && (rd_idx_reg == LEN_LO_WORD)) begin
            msg_word = bit_len[31:0];
        end else if (len_blk && (rd_idx_reg == LEN_HI_WORD)) begin
            msg_word = bit_len[63:32];
        end
    end

    // Round function
    always_comb begin
        case (cmd.rnd[5:4])
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2:    f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
    end

    assign sum   = f_val + a_reg + msg_word + SINE_TABLE[cmd.rnd];
    assign b_new = b_reg + md5sh_rotl(sum, md5sh_shift(cmd.rnd));

    // Advance the working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
        end else if (cmd.round) begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_new;
        end
    end

    // Chaining words and length counter
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.reinit) begin
            chain_reg[0] <= IV_A;
            chain_reg[1] <= IV_B;
            chain_reg[2] <= IV_C;
            chain_reg[3] <= IV_D;
            byte_cnt_reg <= '0;
        end else begin
            if (cmd.finish) begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
            end
            if (cmd.byte_wr) begin
                byte_cnt_reg <= byte_cnt_reg + 61'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: streaming MD5 hasher
// Feeds message bytes over the input stream, with tlast closing each message,
// and checks every digest word against an in-bench MD5 predictor or a digest
// typed in a directed row. A short table of directed transactions comes
// first, then a padding overflow message, an exact one-block message and
// short random messages, under three idling phases.
// ----------------------------------------------------------------------------

module testbench;

    // One expected digest word on the result stream
    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  idx;
        logic        last;
    } digest_beat_t;

    // One directed transaction; digest holds {D, C, B, A} when known is set
    typedef struct packed {
        logic [7:0]   data;
        logic         present;
        logic         last;
        logic         known;
        logic [127:0] digest;
    } stim_row_t;

    localparam logic [127:0] DIGEST_EMPTY = 128'h7e42f8ec_980980e9_04b2008f_d98c1dd4;
    localparam logic [127:0] DIGEST_A     = 128'h61267769_e299c331_a8b6f1c0_b975c10c;

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int ROT_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                    4, 11, 16, 23, 6, 10, 15, 21};

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic [0:0]  s_tuser;   // [0] byte_present
    logic        s_tlast;   // end_of_message
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] digest_word
    logic [1:0]  m_tuser;   // [1:0] word_sel
    logic        m_tlast;   // last_word

    // Predictor state of the hash in progress
    logic [31:0] chain_words [4];
    logic [7:0]  msg_block [64];
    logic [63:0] msg_bits;

    digest_beat_t digest_due [$];
    digest_beat_t want;
    stim_row_t    dir_rows [$];

    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    int unsigned fail_count;
    int unsigned phase_items;
    int unsigned phase_msgs;
    int unsigned msg_total;
    int unsigned msg_len;

    md5_stream_hasher_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // Restore the initial chain and clear the message length
    function automatic void restart_hash();
        chain_words[0] = 32'h67452301;
        chain_words[1] = 32'hefcdab89;
        chain_words[2] = 32'h98badcfe;
        chain_words[3] = 32'h10325476;
        msg_bits = '0;
        for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    endfunction

    // Run the 64 rounds over the buffered block and fold into the chain
    function automatic void compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, f, t;
        int g;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i+3], msg_block[4*i+2], msg_block[4*i+1], msg_block[4*i]};
        a = chain_words[0];
        b = chain_words[1];
        c = chain_words[2];
        d = chain_words[3];
        for (int r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin
                    f = (b & c) | (~b & d);
                    g = r;
                end
                1: begin
                    f = (b & d) | (c & ~d);
                    g = (5 * r + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * r + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * r) % 16;
                end
            endcase
            t = a + f + w[g] + ROUND_CONST[r];
            a = d;
            d = c;
            c = b;
            b = b + rol32(t, ROT_AMT[(r / 16) * 4 + r % 4]);
        end
        chain_words[0] += a;
        chain_words[1] += b;
        chain_words[2] += c;
        chain_words[3] += d;
    endfunction

    // Absorb one accepted transaction; on end of message queue the digest words
    function automatic void absorb_byte(input logic [7:0] d, input logic p, input logic l);
        int fill;
        logic [63:0] len;
        digest_beat_t beat;
        fill = msg_bits[8:3];
        if (p) begin
            msg_block[fill] = d;
            msg_bits += 64'd8;
            fill = (fill + 1) % 64;
            if (fill == 0) compress_block();
        end
        if (!l) return;
        len = msg_bits;
        msg_block[fill] = 8'h80;
        for (int i = fill + 1; i < 64; i++) msg_block[i] = 8'h00;
        // no room left for the length: close this block and pad a fresh one
        if (fill >= 56) begin
            compress_block();
            for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
        end
        for (int i = 0; i < 8; i++) msg_block[56 + i] = len[8*i +: 8];
        compress_block();
        for (int i = 0; i < 4; i++) begin
            beat.word = chain_words[i];
            beat.idx  = 2'(i);
            beat.last = (i == 3);
            digest_due.push_back(beat);
        end
        restart_hash();
    endfunction

    function automatic stim_row_t row(input logic [7:0] d, input logic p, input logic l,
                                      input logic k, input logic [127:0] dg);
        stim_row_t r;
        r.data    = d;
        r.present = p;
        r.last    = l;
        r.known   = k;
        r.digest  = dg;
        return r;
    endfunction

    // Present one transaction from a falling edge and hold it until accepted
    task automatic send_item(input logic [7:0] d, input logic p, input logic l);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= d;
        s_tuser[0] <= p;
        s_tlast    <= l;
        do @(posedge aclk); while (!s_tready);
        absorb_byte(d, p, l);
        @(negedge aclk);
    endtask

    // Send one message of n bytes with random content and idle noise
    task automatic send_message(input int unsigned n);
        logic carry_last;
        carry_last = (n > 0) && ($urandom_range(1) == 1);
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, carry_last && (i == n - 1));
            phase_items++;
        end
        if (!carry_last) begin
            send_item(8'($urandom), 1'b0, 1'b1);
            phase_items++;
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Drive the result-side ready at random
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Compare every accepted digest word with the oldest expectation
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (digest_due.size() == 0) begin
                    $display("%0t: unexpected digest word: expected none, got %h idx %0d last %0b",
                             $time, m_tdata, m_tuser, m_tlast);
                    fail_count++;
                end else begin
                    want = digest_due.pop_front();
                    if (m_tdata !== want.word) begin
                        $display("%0t: digest_word mismatch: expected %h, got %h",
                                 $time, want.word, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser !== want.idx) begin
                        $display("%0t: word_sel mismatch: expected %0d, got %0d",
                                 $time, want.idx, m_tuser);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t: last_word mismatch: expected %0b, got %0b",
                                 $time, want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        s_tuser      = 1'b0;
        s_tlast      = 1'b0;
        fail_count   = 0;
        msg_total    = 0;
        src_idle_pct = 13;
        snk_idle_pct = 61;
        restart_hash();

        // Directed transactions: idle, empty message, single bytes, extremes
        dir_rows.push_back(row(8'hff, 1'b0, 1'b0, 1'b0, '0));
        dir_rows.push_back(row(8'h00, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY));
        dir_rows.push_back(row(8'h61, 1'b1, 1'b1, 1'b1, DIGEST_A));
        dir_rows.push_back(row(8'h00, 1'b0, 1'b0, 1'b0, '0));
        dir_rows.push_back(row(8'h00, 1'b1, 1'b0, 1'b0, '0));
        dir_rows.push_back(row(8'hff, 1'b1, 1'b0, 1'b0, '0));
        dir_rows.push_back(row(8'ha5, 1'b0, 1'b0, 1'b0, '0));
        dir_rows.push_back(row(8'h80, 1'b1, 1'b0, 1'b0, '0));
        dir_rows.push_back(row(8'h7f, 1'b1, 1'b1, 1'b0, '0));
        dir_rows.push_back(row(8'hff, 1'b1, 1'b1, 1'b0, '0));
        dir_rows.push_back(row(8'h5a, 1'b0, 1'b0, 1'b0, '0));
        dir_rows.push_back(row(8'hff, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY));
        dir_rows.push_back(row(8'h61, 1'b1, 1'b0, 1'b0, '0));
        dir_rows.push_back(row(8'h62, 1'b1, 1'b0, 1'b0, '0));
        dir_rows.push_back(row(8'h63, 1'b1, 1'b1, 1'b0, '0));
        dir_rows.push_back(row(8'h00, 1'b1, 1'b0, 1'b0, '0));
        dir_rows.push_back(row(8'hff, 1'b1, 1'b0, 1'b0, '0));
        dir_rows.push_back(row(8'h01, 1'b1, 1'b0, 1'b0, '0));
        dir_rows.push_back(row(8'hfe, 1'b1, 1'b0, 1'b0, '0));
        dir_rows.push_back(row(8'h3c, 1'b0, 1'b1, 1'b0, '0));

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].data, dir_rows[i].present, dir_rows[i].last);
            // replace the predicted digest with the typed one
            if (dir_rows[i].known) begin
                repeat (4) void'(digest_due.pop_back());
                for (int k = 0; k < 4; k++) begin
                    want.word = dir_rows[i].digest[32*k +: 32];
                    want.idx  = 2'(k);
                    want.last = (k == 3);
                    digest_due.push_back(want);
                end
            end
        end

        // Random messages under three idling phases
        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 61 : 0;
            snk_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 13 : 0;
            phase_items  = 0;
            phase_msgs   = 0;
            while (phase_items < 10 || phase_msgs < 1) begin
                // force a padding overflow and an exact block early on
                if (msg_total == 0)
                    msg_len = $urandom_range(58, 56);
                else if (msg_total == 1)
                    msg_len = 64;
                else
                    msg_len = $urandom_range(12, 0);
                send_message(msg_len);
                phase_msgs++;
                msg_total++;
            end
        end
        s_tvalid <= 1'b0;

        // Drain outstanding digest words, then watch for stray ones
        while (digest_due.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
